### rtl/congestion_frame_drop_queue_unit_macros.svh
// assertion macros for the frame drop queue checker
`ifndef CONGESTION_FRAME_DROP_QUEUE_UNIT_MACROS_SVH
`define CONGESTION_FRAME_DROP_QUEUE_UNIT_MACROS_SVH
// implication checked on every clock, quiet in reset
`define CFDQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// next-cycle implication
`define CFDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

### rtl/cfdq_pkg.sv
// package of the frame drop queue: constants and types
`timescale 1ns / 1ps
`default_nettype none
package cfdq_pkg;
	localparam logic [1:0] OP_AUDIO = 2'd0;
	localparam logic [1:0] OP_VIDEO = 2'd1;
	localparam logic [1:0] OP_POP = 2'd2;
	localparam logic [1:0] OP_POP_ALT = 2'd3;
	localparam logic [2:0] ST_QUEUED = 3'd0;
	localparam logic [2:0] ST_GATE_DROP = 3'd1;
	localparam logic [2:0] ST_FULL_DROP = 3'd2;
	localparam logic [2:0] ST_POPPED = 3'd3;
	localparam logic [2:0] ST_POP_EMPTY = 3'd4;
	localparam logic [0:0] CFG_BFRAME = 1'd0;
	localparam logic [0:0] CFG_PFRAME = 1'd1;
	localparam logic [25:0] BFRAME_RESET = 26'd700000;
	localparam logic [25:0] PFRAME_RESET = 26'd900000;
	localparam logic [26:0] P_MARGIN = 27'd200000;
	typedef struct packed {
		logic [1:0]  operation;
		logic [1:0]  pkt_prio;
		logic        keyframe;
		logic [47:0] pkt_time_us;
		logic [15:0] packet_tag;
	} cmd_t;
	typedef struct packed {
		logic [2:0]  status;
		logic        out_is_video;
		logic        out_keyframe;
		logic [1:0]  out_priority;
		logic [47:0] out_time_us;
		logic [15:0] out_tag;
		logic [6:0]  queue_count;
		logic [6:0]  dropped_in_step;
		logic [31:0] dropped_total;
	} res_t;
	typedef struct packed {
		logic        index;
		logic [25:0] data;
	} cfg_t;
	// entry as held in the store
	typedef struct packed {
		logic [15:0] tag;
		logic [1:0]  prio;
		logic        key;
		logic        video;
		logic [47:0] dts;
	} entry_t;
endpackage
`default_nettype wire

### rtl/cfdq_if.sv
// valid/ready channel interfaces of the frame drop queue
`timescale 1ns / 1ps
`default_nettype none
interface cfdq_cmd_if import cfdq_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface cfdq_res_if import cfdq_pkg::*; ();
	logic valid;
	logic ready;
	res_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface cfdq_cfg_if import cfdq_pkg::*; ();
	logic valid;
	logic ready;
	cfg_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/cfdq_store.sv
// entry memory of the frame drop queue, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module cfdq_store import cfdq_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);
	entry_t mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/congestion_frame_drop_queue_unit.sv
// top level of the frame drop queue
//
// channel | dir | word
// cmd     | in  | operation, pkt_prio, keyframe, pkt_time_us, packet_tag
// res     | out | status, popped entry fields, queue_count, drop counts
// cfg     | in  | register index and threshold data
//
// one word at a time through a sequencer around one shared entry memory
// push writes the new entry at the tail; pop reads the head, then moves each entry down one place
// video push: each check scans for the first non-key video, then compacts the queue
// every memory read goes through the registered read port; the result sits in an output register
// reset clears control state only; the entry memory is never cleared
`timescale 1ns / 1ps
`default_nettype none
module congestion_frame_drop_queue_unit import cfdq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int MIN_QUEUED_FOR_CHECK = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	cfdq_cmd_if.sink cmd,
	cfdq_res_if.source res,
	cfdq_cfg_if.sink cfg
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] MINQ_C = CW'(MIN_QUEUED_FOR_CHECK);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_FIND = 4'd2;   // scan for first non-key video
	localparam logic [3:0] S_FIND_W = 4'd3;
	localparam logic [3:0] S_COMP = 4'd4;   // compact
	localparam logic [3:0] S_COMP_W = 4'd5;
	localparam logic [3:0] S_GATE = 4'd6;
	localparam logic [3:0] S_POP_W = 4'd7;
	localparam logic [3:0] S_SHIFT = 4'd8;
	localparam logic [3:0] S_SHIFT_W = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0]    state_q;
	cmd_t          cmd_q;
	logic [25:0]   bthr_q, pthr_q;
	logic [CW-1:0] count_q;
	logic [1:0]    minprio_q;
	logic [47:0]   last_vid_q;
	logic [31:0]   total_q;
	logic [6:0]    drop_q;
	logic          level3_q;    // second check running
	logic [CW-1:0] rd_q, wr_q;  // scan pointers
	logic          res_valid_q;
	res_t          res_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;

	cfdq_store #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// effective thresholds
	logic [26:0] bmin, pthr_eff, thr;
	logic [1:0]  level;
	assign bmin = {1'b0, bthr_q} + P_MARGIN;
	assign pthr_eff = ({1'b0, pthr_q} < bmin) ? bmin : {1'b0, pthr_q};
	assign thr = level3_q ? pthr_eff : {1'b0, bthr_q};
	assign level = level3_q ? 2'd3 : 2'd2;

	// signed duration from the scanned entry, 49 bits wide
	logic signed [48:0] dur;
	assign dur = $signed({last_vid_q[47], last_vid_q}) - $signed({rdata.dts[47], rdata.dts});

	logic keep;
	assign keep = !rdata.video || (rdata.prio >= level);

	entry_t new_entry;
	always_comb begin
		new_entry.tag = cmd_q.packet_tag;
		new_entry.prio = cmd_q.pkt_prio;
		new_entry.key = cmd_q.keyframe;
		new_entry.video = (cmd_q.operation == OP_VIDEO);
		new_entry.dts = cmd_q.pkt_time_us;
	end

	assign raddr = rd_q[AW-1:0];
	assign cmd.ready = (state_q == S_IDLE) && !res_valid_q;
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid_q;
	assign res.payload = res_q;

	always_comb begin
		we = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = rdata;
		case (state_q)
			S_DISPATCH: begin
				// audio push writes directly
				we = (cmd_q.operation == OP_AUDIO) && (count_q < DEPTH_C);
				waddr = count_q[AW-1:0];
				wdata = new_entry;
			end
			S_GATE: begin
				we = (cmd_q.pkt_prio >= minprio_q) && (count_q < DEPTH_C);
				waddr = count_q[AW-1:0];
				wdata = new_entry;
			end
			S_COMP: we = keep;
			S_SHIFT: we = 1'b1;
			default: ;
		endcase
	end

	// saturating add of the step's drops
	logic [32:0] tot_sum;
	assign tot_sum = {1'b0, total_q} + 33'(drop_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= '0;
			bthr_q <= BFRAME_RESET;
			pthr_q <= PFRAME_RESET;
			count_q <= '0;
			minprio_q <= '0;
			last_vid_q <= '0;
			total_q <= '0;
			drop_q <= '0;
			level3_q <= 1'b0;
			rd_q <= '0;
			wr_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cfg.valid) begin
				if (cfg.payload.index == CFG_BFRAME) bthr_q <= cfg.payload.data;
				else pthr_q <= cfg.payload.data;
			end
			if (res_valid_q && res.ready) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd.valid && cmd.ready) begin
						cmd_q <= cmd.payload;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					// only a full audio push drops here
					drop_q <= 7'((cmd_q.operation == OP_AUDIO) && (count_q >= DEPTH_C));
					res_q.out_is_video <= 1'b0;
					res_q.out_keyframe <= 1'b0;
					res_q.out_priority <= '0;
					res_q.out_time_us <= '0;
					res_q.out_tag <= '0;
					rd_q <= '0;
					wr_q <= '0;
					level3_q <= 1'b0;
					if (cmd_q.operation inside {OP_POP, OP_POP_ALT}) begin
						if (count_q == '0) begin
							res_q.status <= ST_POP_EMPTY;
							state_q <= S_DONE;
						end else begin
							res_q.status <= ST_POPPED;
							state_q <= S_POP_W;
						end
					end else if (cmd_q.operation == OP_AUDIO) begin
						if (count_q < DEPTH_C) begin
							count_q <= count_q + 1'b1;
							res_q.status <= ST_QUEUED;
						end else begin
							res_q.status <= ST_FULL_DROP;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= (count_q < MINQ_C) ? S_GATE : S_FIND_W;
					end
				end
				S_FIND_W: state_q <= S_FIND;
				S_FIND: begin
					if (rd_q >= count_q) begin
						// no non-key video: check does not fire
						rd_q <= '0;
						if (level3_q || count_q < MINQ_C) state_q <= S_GATE;
						else begin level3_q <= 1'b1; state_q <= S_FIND_W; end
					end else if (rdata.video && !rdata.key) begin
						rd_q <= '0;
						wr_q <= '0;
						if (dur > $signed({22'd0, thr})) begin
							state_q <= S_COMP_W;
						end else if (level3_q) begin
							state_q <= S_GATE;
						end else begin
							level3_q <= 1'b1;
							state_q <= (count_q < MINQ_C) ? S_GATE : S_FIND_W;
						end
					end else begin
						rd_q <= rd_q + 1'b1;
						state_q <= S_FIND_W;
					end
				end
				S_COMP_W: state_q <= S_COMP;
				S_COMP: begin
					if (keep) wr_q <= wr_q + 1'b1;
					if (rd_q + 1'b1 >= count_q) begin
						drop_q <= drop_q + 7'(count_q - wr_q - CW'(keep));
						count_q <= wr_q + CW'(keep);
						if (minprio_q < level) minprio_q <= level;
						rd_q <= '0;
						if (level3_q || (wr_q + CW'(keep)) < MINQ_C) begin
							state_q <= S_GATE;
						end else begin
							level3_q <= 1'b1;
							state_q <= S_FIND_W;
						end
					end else begin
						rd_q <= rd_q + 1'b1;
						state_q <= S_COMP_W;
					end
				end
				S_GATE: begin
					if (cmd_q.pkt_prio < minprio_q) begin
						res_q.status <= ST_GATE_DROP;
						drop_q <= drop_q + 7'd1;
					end else begin
						minprio_q <= '0;
						if (count_q < DEPTH_C) begin
							count_q <= count_q + 1'b1;
							last_vid_q <= cmd_q.pkt_time_us;
							res_q.status <= ST_QUEUED;
						end else begin
							res_q.status <= ST_FULL_DROP;
							drop_q <= drop_q + 7'd1;
						end
					end
					state_q <= S_DONE;
				end
				S_POP_W: begin
					rd_q <= CW'(1);
					wr_q <= '0;
					state_q <= S_SHIFT_W;
				end
				S_SHIFT_W: begin
					if (wr_q == '0) begin
						// head entry is on the read port now
						res_q.out_is_video <= rdata.video;
						res_q.out_keyframe <= rdata.key;
						res_q.out_priority <= rdata.prio;
						res_q.out_time_us <= rdata.dts;
						res_q.out_tag <= rdata.tag;
					end
					if (rd_q >= count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					// read data is entry rd_q, written one lower
					wr_q <= wr_q + 1'b1;
					rd_q <= rd_q + 1'b1;
					state_q <= S_SHIFT_W;
				end
				S_DONE: begin
					res_q.queue_count <= 7'(count_q);
					res_q.dropped_in_step <= drop_q;
					res_q.dropped_total <= tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
					total_q <= tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
					res_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/cfdq_checker.sv
// port-level assertions of the frame drop queue and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "congestion_frame_drop_queue_unit_macros.svh"
module cfdq_checker import cfdq_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_ready,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire res_t res_payload
);
	// a word taken leaves the block busy
	`CFDQ_ASSERT_NEXT(a_busy_after_take, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)
	// no new word while a result waits
	`CFDQ_ASSERT_IMP(a_no_take_with_result, clk, arst_n, res_valid, !cmd_ready)
	// a waiting result holds
	`CFDQ_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_payload))
	// status code stays in range
	`CFDQ_ASSERT_IMP(a_status_range, clk, arst_n, res_valid, res_payload.status <= ST_POP_EMPTY)
endmodule

bind congestion_frame_drop_queue_unit cfdq_checker u_cfdq_checker (
	.clk(clk), .arst_n(arst_n), .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
	.res_valid(res.valid), .res_ready(res.ready), .res_payload(res.payload)
);
`default_nettype wire
